[rtl/core/ccs_pkg.sv]
// ---------------------------------------------------------------------------
// ccs_pkg: shared types and constants for the comment stripper
// Byte codes, scanner state encoding and the action record that passes
// from the scanner to the output sequencer.
// ---------------------------------------------------------------------------
package ccs_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Scanner states
    typedef enum logic [2:0] {
        ST_PLAIN = 3'd0,
        ST_SLASH = 3'd1,
        ST_BLOCK = 3'd2,
        ST_BSTAR = 3'd3,
        ST_LINE  = 3'd4
    } scan_state_t;

    // One queued action: one or two output words for a single input word
    typedef struct packed {
        logic [7:0] ch0;     // first output byte (0 when empty)
        logic [7:0] ch1;     // second output byte
        logic       two;     // two words to send
        logic       empty;   // single word without a byte (end marker only)
        logic       fin;     // last action of the text
        logic       unterm;  // text ended inside a block comment
    } ccs_rec_t;

    // Queue handshake between scanner and sequencer
    typedef struct packed {
        logic full;
        logic empty;
    } ccs_q_stat_t;

endpackage

[rtl/core/ccs_front.sv]
// ---------------------------------------------------------------------------
// ccs_front: comment scanner
// Tracks the lexical state per input word and turns each word into an
// action record for the queue; words that produce nothing are not queued.
// ---------------------------------------------------------------------------
module ccs_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_char,
    input  logic                 is_final,
    input  ccs_pkg::ccs_q_stat_t q_stat,
    output logic                 push,
    output ccs_pkg::ccs_rec_t    push_rec
);
    import ccs_pkg::*;

    scan_state_t state_reg;
    scan_state_t state_next;
    scan_state_t nx;
    logic        accept;
    logic [1:0]  n_emit;
    logic [7:0]  e0;
    logic [7:0]  e1;
    logic        unterm;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    // Next scanner state for this byte
    always_comb
    begin
        unique case (state_reg)
            ST_SLASH:
            begin
                if (in_char == CH_STAR)
                    nx = ST_BLOCK;
                else if (in_char == CH_SLASH)
                    nx = ST_LINE;
                else
                    nx = ST_PLAIN;
            end
            ST_BLOCK:
                nx = (in_char == CH_STAR) ? ST_BSTAR : ST_BLOCK;
            ST_BSTAR:
            begin
                if (in_char == CH_SLASH)
                    nx = ST_PLAIN;
                else if (in_char == CH_STAR)
                    nx = ST_BSTAR;
                else
                    nx = ST_BLOCK;
            end
            ST_LINE:
                nx = (in_char == CH_NL) ? ST_PLAIN : ST_LINE;
            default:
                nx = (in_char == CH_SLASH) ? ST_SLASH : ST_PLAIN;
        endcase
        state_next = state_reg;
        if (accept)
            state_next = is_final ? ST_PLAIN : nx;
    end

    // Bytes emitted for this input word
    always_comb
    begin
        n_emit = 2'd0;
        e0     = 8'h00;
        e1     = 8'h00;
        unique case (state_reg)
            ST_SLASH:
            begin
                if (in_char == CH_STAR || in_char == CH_SLASH)
                begin
                    n_emit = 2'd1;
                    e0     = CH_SPACE;
                end
                else
                begin
                    n_emit = 2'd2;
                    e0     = CH_SLASH;
                    e1     = in_char;
                end
            end
            ST_BLOCK, ST_BSTAR:
                n_emit = 2'd0;
            ST_LINE:
            begin
                if (in_char == CH_NL)
                begin
                    n_emit = 2'd1;
                    e0     = CH_NL;
                end
            end
            default:
            begin
                if (in_char != CH_SLASH)
                begin
                    n_emit = 2'd1;
                    e0     = in_char;
                end
            end
        endcase

        // Flush a held slash at the end of text
        if (is_final && nx == ST_SLASH)
        begin
            n_emit = 2'd1;
            e0     = CH_SLASH;
        end

        unterm = is_final && (nx == ST_BLOCK || nx == ST_BSTAR);

        push_rec.ch0    = e0;
        push_rec.ch1    = e1;
        push_rec.two    = (n_emit == 2'd2);
        push_rec.empty  = (n_emit == 2'd0);
        push_rec.fin    = is_final;
        push_rec.unterm = unterm;
        // Queue only words that yield a result
        push = accept && (n_emit != 2'd0 || is_final);
    end

    // Hold scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_PLAIN;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/core/ccs_fifo.sv]
// ---------------------------------------------------------------------------
// ccs_fifo: action queue
// Small register queue that decouples the scanner from the output sequencer.
// ---------------------------------------------------------------------------
module ccs_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ccs_pkg::ccs_rec_t    push_rec,
    input  logic                 pop,
    output ccs_pkg::ccs_rec_t    head_rec,
    output ccs_pkg::ccs_q_stat_t stat
);
    import ccs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ccs_rec_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_rec   = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

[rtl/core/ccs_back.sv]
// ---------------------------------------------------------------------------
// ccs_back: output sequencer
// Takes action records from the queue into an output register and sends
// one or two words per record on the result stream.
// ---------------------------------------------------------------------------
module ccs_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccs_pkg::ccs_rec_t    head_rec,
    input  ccs_pkg::ccs_q_stat_t q_stat,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_char,
    output logic                 char_valid,
    output logic                 run_last,
    output logic                 text_end,
    output logic                 unterminated
);
    import ccs_pkg::*;

    ccs_rec_t rec_reg;
    logic     busy_reg;
    logic     busy_next;
    logic     phase_reg;
    logic     phase_next;
    logic     take;
    logic     last_word;

    assign take      = out_valid && out_ready;
    assign last_word = !rec_reg.two || phase_reg;
    assign pop       = (!busy_reg || (take && last_word)) && !q_stat.empty;

    // Advance through the words of the current record
    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        if (pop)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
        end
        else if (take && last_word)
            busy_next = 1'b0;
        else if (take)
            phase_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

    // Load the next record
    always_ff @(posedge clk)
    begin
        if (pop)
            rec_reg <= head_rec;
    end

    // Drive the current word
    assign out_valid    = busy_reg;
    assign out_char     = phase_reg ? rec_reg.ch1 : rec_reg.ch0;
    assign char_valid   = !rec_reg.empty;
    assign run_last     = last_word;
    assign text_end     = last_word && rec_reg.fin;
    assign unterminated = last_word && rec_reg.unterm;

endmodule

[rtl/core/comment_to_space_stripper.sv]
// ---------------------------------------------------------------------------
// comment_to_space_stripper: replace C/C++ comments with one space
// Streams source bytes in, streams bytes out with every comment collapsed
// to a single space and an end-of-text word carrying the unterminated flag.
// ---------------------------------------------------------------------------
// An input word is accepted in every cycle while the action queue has room;
// the scanner decides each byte combinationally. The output side sends one
// word per cycle while the receiver is ready, so an input byte that yields
// two output bytes (a held slash followed by an ordinary byte) occupies the
// output port for two words, and an input byte inside a comment yields no
// output word unless it ends the text. A result passes through the queue,
// written when its input word is accepted, and then the output register,
// which loads from the queue head once the sequencer is free. Pending
// work is bounded by FIFO_DEPTH plus the output register.
module comment_to_space_stripper
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,   // is_final
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,   // run_last
    output logic [2:0] m_tuser    // [0] char_valid, [1] text_end, [2] unterminated
);
    import ccs_pkg::*;

    ccs_q_stat_t q_stat;
    ccs_rec_t    push_rec;
    ccs_rec_t    head_rec;
    logic        push;
    logic        pop;

    ccs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_char  (s_tdata),
        .is_final (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .push_rec (push_rec)
    );

    ccs_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .stat     (q_stat)
    );

    ccs_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_rec     (head_rec),
        .q_stat       (q_stat),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_char     (m_tdata),
        .char_valid   (m_tuser[0]),
        .run_last     (m_tlast),
        .text_end     (m_tuser[1]),
        .unterminated (m_tuser[2])
    );

endmodule

[rtl/core/ccs_checker.sv]
// ---------------------------------------------------------------------------
// ccs_checker: port-level checks for the comment stripper
// Watches the result stream for consistent end-of-text flags and stalls.
// ---------------------------------------------------------------------------
module ccs_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    input  logic [2:0] m_tuser
);

    // No result word while held in reset
    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result word valid during reset");

    // A stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result word changed");

    // End of text closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("text end without run last");

    // Unterminated flag only on the end-of-text word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1])
        else $error("unterminated flag outside text end");

    // A word without a byte is the bare end marker with a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && (m_tdata == 8'h00))
        else $error("empty word is not a clean end marker");

endmodule

bind comment_to_space_stripper ccs_checker u_ccs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

[tb/sv/tb_comment_to_space_stripper.sv]
// ---------------------------------------------------------------------------
// tb_comment_to_space_stripper: self-checking bench for the comment stripper
// Streams source text through the block and checks each output word against
// an in-bench scanner model. A table of hand-written texts comes first, then
// random texts built from plain runs, block and line comments, stray slashes
// and raw noise bytes. Both stream sides idle in random bursts.
// ---------------------------------------------------------------------------
module tb_comment_to_space_stripper;

    import ccs_pkg::*;

    localparam int RAND_ITEMS     = 1150;
    localparam int QUIET_TAIL     = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // One output word as the block sends it
    typedef struct packed {
        logic [7:0] ch;
        logic       char_valid;
        logic       run_last;
        logic       text_end;
        logic       unterm;
    } strip_word_t;

    // One directed input word; typed rows carry their single expected word
    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic        typed;
        strip_word_t want;
    } dir_row_t;

    localparam strip_word_t NO_WORD = '0;
    localparam int DIR_N = 27;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{8'h41,    1'b0, 1'b1, '{8'h41,    1'b1, 1'b1, 1'b0, 1'b0}},
        '{8'h00,    1'b0, 1'b1, '{8'h00,    1'b1, 1'b1, 1'b0, 1'b0}},
        '{8'hFF,    1'b0, 1'b1, '{8'hFF,    1'b1, 1'b1, 1'b0, 1'b0}},
        // held slash released by an ordinary byte
        '{CH_SLASH, 1'b0, 1'b0, NO_WORD},
        '{8'h78,    1'b0, 1'b0, NO_WORD},
        // block comment with runs of stars before the close
        '{CH_SLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_STAR,  1'b0, 1'b1, '{CH_SPACE, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{CH_STAR,  1'b0, 1'b0, NO_WORD},
        '{CH_STAR,  1'b0, 1'b0, NO_WORD},
        '{8'h71,    1'b0, 1'b0, NO_WORD},
        '{CH_STAR,  1'b0, 1'b0, NO_WORD},
        '{CH_SLASH, 1'b0, 1'b0, NO_WORD},
        // line comment, newline passed through
        '{CH_SLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_SLASH, 1'b0, 1'b1, '{CH_SPACE, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{8'h7A,    1'b0, 1'b0, NO_WORD},
        '{CH_NL,    1'b0, 1'b1, '{CH_NL,    1'b1, 1'b1, 1'b0, 1'b0}},
        // text ends on a lone slash
        '{CH_SLASH, 1'b1, 1'b1, '{CH_SLASH, 1'b1, 1'b1, 1'b1, 1'b0}},
        // text ends right after the slash-star opener
        '{CH_SLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_STAR,  1'b1, 1'b1, '{CH_SPACE, 1'b1, 1'b1, 1'b1, 1'b1}},
        // text ends inside a line comment
        '{CH_SLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_SLASH, 1'b0, 1'b0, NO_WORD},
        '{8'h61,    1'b1, 1'b1, '{8'h00,    1'b0, 1'b1, 1'b1, 1'b0}},
        // text ends inside a block comment body
        '{CH_SLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_STAR,  1'b0, 1'b0, NO_WORD},
        '{8'h62,    1'b1, 1'b1, '{8'h00,    1'b0, 1'b1, 1'b1, 1'b1}},
        // final byte releases a held slash: two words, end on the second
        '{CH_SLASH, 1'b0, 1'b0, NO_WORD},
        '{8'h65,    1'b1, 1'b0, NO_WORD}
    };

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] in_char
    logic       s_tlast;   // is_final
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_char
    logic       m_tlast;   // run_last
    logic [2:0] m_tuser;   // [0] char_valid, [1] text_end, [2] unterminated

    scan_state_t scan_st;
    strip_word_t stripped_q [$];
    strip_word_t pred_words [2];
    bit          idle_on;
    int          errors;
    int          quiet_cycles;

    comment_to_space_stripper uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report(input string msg);
        begin
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        end
    endtask

    // Advance the scanner by one byte; fill pred_words and return their count
    function automatic int strip_predict(input logic [7:0] c, input logic fin);
        logic [7:0]  emit [2];
        int          n;
        scan_state_t nx;
        logic        unt;
        begin
            n = 0;
            case (scan_st)
                ST_SLASH:
                begin
                    if (c == CH_STAR)
                    begin
                        emit[n] = CH_SPACE; n++;
                        nx = ST_BLOCK;
                    end
                    else if (c == CH_SLASH)
                    begin
                        emit[n] = CH_SPACE; n++;
                        nx = ST_LINE;
                    end
                    else
                    begin
                        emit[n] = CH_SLASH; n++;
                        emit[n] = c;        n++;
                        nx = ST_PLAIN;
                    end
                end
                ST_BLOCK:
                    nx = (c == CH_STAR) ? ST_BSTAR : ST_BLOCK;
                ST_BSTAR:
                begin
                    if (c == CH_SLASH)
                        nx = ST_PLAIN;
                    else if (c == CH_STAR)
                        nx = ST_BSTAR;
                    else
                        nx = ST_BLOCK;
                end
                ST_LINE:
                begin
                    if (c == CH_NL)
                    begin
                        emit[n] = CH_NL; n++;
                        nx = ST_PLAIN;
                    end
                    else
                        nx = ST_LINE;
                end
                default:
                begin
                    if (c == CH_SLASH)
                        nx = ST_SLASH;
                    else
                    begin
                        emit[n] = c; n++;
                        nx = ST_PLAIN;
                    end
                end
            endcase

            if (fin)
            begin
                // end of text: flush a held slash, always close with an end word
                unt = (nx == ST_BLOCK) || (nx == ST_BSTAR);
                if (nx == ST_SLASH)
                begin
                    emit[n] = CH_SLASH; n++;
                end
                if (n == 0)
                begin
                    pred_words[0] = '{8'h00, 1'b0, 1'b1, 1'b1, unt};
                    n = 1;
                end
                else
                    for (int k = 0; k < n; k++)
                        pred_words[k] = '{emit[k], 1'b1, k == n - 1, k == n - 1,
                                          (k == n - 1) && unt};
                scan_st = ST_PLAIN;
            end
            else
            begin
                for (int k = 0; k < n; k++)
                    pred_words[k] = '{emit[k], 1'b1, k == n - 1, 1'b0, 1'b0};
                scan_st = nx;
            end
            return n;
        end
    endfunction

    // Send one word, wait for acceptance, then queue what it should produce
    task automatic accept_word(input logic [7:0] ch, input logic fin,
                               input logic typed, input strip_word_t want);
        int gap;
        int n;
        begin
            gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            s_tvalid <= 1'b1;
            s_tdata  <= ch;
            s_tlast  <= fin;
            do
                @(posedge clk);
            while (!s_tready);

            n = strip_predict(ch, fin);
            if (typed)
                stripped_q.push_back(want);
            else
                for (int k = 0; k < n; k++)
                    stripped_q.push_back(pred_words[k]);
        end
    endtask

    // Source-like byte: mostly printable, with comment markers and noise mixed in
    function automatic logic [7:0] text_byte();
        begin
            case ($urandom_range(0, 9))
                0:       return 8'($urandom_range(0, 255));
                1:       return CH_NL;
                2:       return CH_STAR;
                3:       return CH_SLASH;
                default: return 8'($urandom_range(8'h20, 8'h7E));
            endcase
        end
    endfunction

    // Receiver side: random stall bursts while idling is enabled
    initial
    begin : sink
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                stall = $urandom_range(1, 12) - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Compare each accepted output word with the oldest expectation
    always @(posedge clk)
    begin
        strip_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (stripped_q.size() == 0)
                report($sformatf("unexpected word data=%02h user=%03b last=%0b",
                                 m_tdata, m_tuser, m_tlast));
            else
            begin
                want = stripped_q.pop_front();
                if (m_tdata !== want.ch)
                    report($sformatf("out_char %02h, want %02h", m_tdata, want.ch));
                if (m_tuser[0] !== want.char_valid)
                    report($sformatf("char_valid %0b, want %0b", m_tuser[0],
                                     want.char_valid));
                if (m_tlast !== want.run_last)
                    report($sformatf("run_last %0b, want %0b", m_tlast, want.run_last));
                if (m_tuser[1] !== want.text_end)
                    report($sformatf("text_end %0b, want %0b", m_tuser[1],
                                     want.text_end));
                if (m_tuser[2] !== want.unterm)
                    report($sformatf("unterminated %0b, want %0b", m_tuser[2],
                                     want.unterm));
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0] text [$];
        int         sent;
        int         len_goal;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tlast      = 1'b0;
        idle_on      = 1'b0;
        errors       = 0;
        scan_st      = ST_PLAIN;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed texts
        for (int i = 0; i < DIR_N; i++)
            accept_word(DIR_ROWS[i].ch, DIR_ROWS[i].fin, DIR_ROWS[i].typed,
                        DIR_ROWS[i].want);

        // Random texts, mostly well-formed comment structure with random content
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            text.delete();
            len_goal = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                    : $urandom_range(4, 40);
            if ($urandom_range(0, 3) == 0)
                repeat (len_goal) text.push_back(text_byte());
            else
                while (text.size() < len_goal)
                begin
                    case ($urandom_range(0, 5))
                        0, 1:
                            repeat ($urandom_range(1, 6))
                                text.push_back(8'($urandom_range(8'h20, 8'h7E)));
                        2, 3:
                        begin
                            text.push_back(CH_SLASH);
                            text.push_back(CH_STAR);
                            repeat ($urandom_range(0, 6))
                                text.push_back($urandom_range(0, 2) == 0 ? CH_STAR
                                                                          : text_byte());
                            if ($urandom_range(0, 5) != 0)
                            begin
                                repeat ($urandom_range(1, 3)) text.push_back(CH_STAR);
                                text.push_back(CH_SLASH);
                            end
                        end
                        4:
                        begin
                            text.push_back(CH_SLASH);
                            text.push_back(CH_SLASH);
                            repeat ($urandom_range(0, 6)) text.push_back(text_byte());
                            if ($urandom_range(0, 5) != 0)
                                text.push_back(CH_NL);
                        end
                        default:
                        begin
                            text.push_back(CH_SLASH);
                            text.push_back(8'($urandom_range(0, 255)));
                        end
                    endcase
                end

            // no idling in the tail; otherwise most texts see bursts
            idle_on = (sent < RAND_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < text.size(); i++)
                accept_word(text[i], i == text.size() - 1, 1'b0, NO_WORD);
            sent += text.size();
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        // Drain outstanding words, then watch for strays
        while (stripped_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
